FILE: src/rct_pkg.sv
// ----------------------------------------------------------------------------
// rct_pkg
// Shared types and widths for the concurrency tuner.
// ----------------------------------------------------------------------------
package rct_pkg;

   // field widths
   localparam int LOAD_W = 10;
   localparam int RATE_W = 32;

   // rate divider: dividend is count*256 (17 bit count), divisor is elapsed ticks
   localparam int DVD_W = 25;
   localparam int DVS_W = 32;

   // fit verdict passed from the fit unit to the control
   typedef struct packed {
      logic sc_zero;   // concurrency has no variation
      logic cov_low;   // covariance magnitude below threshold
      logic pos;       // covariance positive
   } fit_res_type;

endpackage

FILE: src/rct_div.sv
// ----------------------------------------------------------------------------
// rct_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rct_div
   import rct_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DVD_W-1:0] dividend,
   input  logic [DVS_W-1:0] divisor,
   output logic             done,
   output logic [DVD_W-1:0] quotient
);

   localparam int SW = $clog2(DVD_W);

   logic             busy_ff;
   logic [SW-1:0]    step_ff;
   logic [DVS_W:0]   rem_ff;
   logic [DVD_W-1:0] quo_ff;
   logic [DVS_W-1:0] dvs_ff;
   logic             done_ff;

   logic [DVS_W:0]   rem_sh;
   logic             fit;

   // shift in next dividend bit, trial subtract
   assign rem_sh = {rem_ff[DVS_W-1:0], quo_ff[DVD_W-1]};
   assign fit    = rem_sh >= {1'b0, dvs_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            step_ff <= '0;
            rem_ff  <= '0;
            quo_ff  <= dividend;
            dvs_ff  <= divisor;
         end else if (busy_ff) begin
            rem_ff  <= fit ? (rem_sh - {1'b0, dvs_ff}) : rem_sh;
            quo_ff  <= {quo_ff[DVD_W-2:0], fit};
            step_ff <= step_ff + 1'b1;
            if (step_ff == SW'(DVD_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

FILE: src/rct_fit.sv
// ----------------------------------------------------------------------------
// rct_fit
// Sample window memory and least-squares fit: walks the window once to build
// the sums, then forms the cross products with shift-add multipliers.
// ----------------------------------------------------------------------------
module rct_fit
   import rct_pkg::*;
#(
   parameter int WINDOW = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              wr_en,
   input  logic [$clog2(WINDOW)-1:0]         wr_addr,
   input  logic [LOAD_W-1:0]                 wr_load,
   input  logic [RATE_W-1:0]                 wr_rate,
   input  logic                              start,
   input  logic [$clog2(WINDOW+1)-1:0]       n,
   output logic                              done,
   output fit_res_type                       res
);

   localparam int NW   = $clog2(WINDOW + 1);
   localparam int IW   = $clog2(WINDOW);
   localparam int CW   = LOAD_W;
   localparam int VW   = RATE_W;
   localparam int SCW  = CW + NW;
   localparam int SVW  = VW + NW;
   localparam int SCCW = 2 * CW + NW;
   localparam int SCVW = CW + VW + NW;
   localparam int PW   = SCVW + NW;
   localparam int TW   = $clog2(SCW + 1);

   localparam logic [2:0] F_IDLE = 3'd0;
   localparam logic [2:0] F_WALK = 3'd1;
   localparam logic [2:0] F_MUL  = 3'd2;
   localparam logic [2:0] F_DIFF = 3'd3;
   localparam logic [2:0] F_RES  = 3'd4;

   // window storage: {load, rate}
   logic [CW+VW-1:0] mem [WINDOW];

   logic [2:0]       state_ff;
   logic [NW-1:0]    n_ff;
   logic [NW-1:0]    iss_ff;
   logic [NW-1:0]    acc_cnt_ff;
   logic             rd_vld_ff;
   logic [CW+VW-1:0] rd_q_ff;
   logic             p_vld_ff;
   logic [CW-1:0]    pc_ff;
   logic [VW-1:0]    pv_ff;
   logic [2*CW-1:0]  pcc_ff;
   logic [CW+VW-1:0] pcv_ff;
   logic [SCW-1:0]   sc_ff;
   logic [SCCW-1:0]  scc_ff;
   logic [SVW-1:0]   sv_ff;
   logic [SCVW-1:0]  scv_ff;
   logic [NW-1:0]    mn_ff;
   logic [SCW-1:0]   msc_ff;
   logic [PW-1:0]    scc_sh_ff, sc_sh_ff, scv_sh_ff, sv_sh_ff;
   logic [PW-1:0]    pa_ff, pb_ff, pc2_ff, pd_ff;
   logic [TW-1:0]    step_ff;
   logic             sc_zero_ff;
   logic [PW:0]      cov_ff;
   logic             done_ff;
   fit_res_type      res_ff;

   logic             issue;
   logic [PW:0]      mag;
   logic [31:0]      mag_scaled;
   logic [31:0]      n_scaled;
   logic             cov_low;

   assign issue = (state_ff == F_WALK) && (iss_ff < n_ff);

   // memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= {wr_load, wr_rate};
      end
      rd_q_ff <= mem[iss_ff[IW-1:0]];
   end

   // covariance threshold test
   assign mag        = cov_ff[PW] ? (~cov_ff + 1'b1) : cov_ff;
   assign mag_scaled = 32'(mag[2:0]) * 32'd10000;
   assign n_scaled   = 32'(n_ff) << 8;
   assign cov_low    = (mag < (PW+1)'(7)) && (mag_scaled < n_scaled);

   // walk, multiply and decide
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= F_IDLE;
         rd_vld_ff <= 1'b0;
         p_vld_ff  <= 1'b0;
         done_ff   <= 1'b0;
      end else begin
         done_ff   <= 1'b0;
         rd_vld_ff <= issue;
         p_vld_ff  <= rd_vld_ff;
         // product stage on the word just read
         pc_ff  <= rd_q_ff[CW+VW-1:VW];
         pv_ff  <= rd_q_ff[VW-1:0];
         pcc_ff <= (2*CW)'(rd_q_ff[CW+VW-1:VW]) * (2*CW)'(rd_q_ff[CW+VW-1:VW]);
         pcv_ff <= (CW+VW)'(rd_q_ff[CW+VW-1:VW]) * (CW+VW)'(rd_q_ff[VW-1:0]);
         case (state_ff)
            F_IDLE: begin
               if (start) begin
                  n_ff       <= n;
                  iss_ff     <= '0;
                  acc_cnt_ff <= '0;
                  sc_ff      <= '0;
                  scc_ff     <= '0;
                  sv_ff      <= '0;
                  scv_ff     <= '0;
                  state_ff   <= F_WALK;
               end
            end
            F_WALK: begin
               if (issue) begin
                  iss_ff <= iss_ff + 1'b1;
               end
               if (p_vld_ff) begin
                  sc_ff      <= sc_ff + SCW'(pc_ff);
                  scc_ff     <= scc_ff + SCCW'(pcc_ff);
                  sv_ff      <= sv_ff + SVW'(pv_ff);
                  scv_ff     <= scv_ff + SCVW'(pcv_ff);
                  acc_cnt_ff <= acc_cnt_ff + 1'b1;
               end
               if (acc_cnt_ff == n_ff) begin
                  mn_ff     <= n_ff;
                  msc_ff    <= sc_ff;
                  scc_sh_ff <= PW'(scc_ff);
                  sc_sh_ff  <= PW'(sc_ff);
                  scv_sh_ff <= PW'(scv_ff);
                  sv_sh_ff  <= PW'(sv_ff);
                  pa_ff     <= '0;
                  pb_ff     <= '0;
                  pc2_ff    <= '0;
                  pd_ff     <= '0;
                  step_ff   <= '0;
                  state_ff  <= F_MUL;
               end
            end
            F_MUL: begin
               // n*scc, sc*sc, n*scv, sc*sv one multiplier bit per cycle
               if (mn_ff[0]) begin
                  pa_ff  <= pa_ff + scc_sh_ff;
                  pc2_ff <= pc2_ff + scv_sh_ff;
               end
               if (msc_ff[0]) begin
                  pb_ff <= pb_ff + sc_sh_ff;
                  pd_ff <= pd_ff + sv_sh_ff;
               end
               mn_ff     <= mn_ff >> 1;
               msc_ff    <= msc_ff >> 1;
               scc_sh_ff <= scc_sh_ff << 1;
               sc_sh_ff  <= sc_sh_ff << 1;
               scv_sh_ff <= scv_sh_ff << 1;
               sv_sh_ff  <= sv_sh_ff << 1;
               step_ff   <= step_ff + 1'b1;
               if (step_ff == TW'(SCW - 1)) begin
                  state_ff <= F_DIFF;
               end
            end
            F_DIFF: begin
               sc_zero_ff <= (pa_ff == pb_ff);
               cov_ff     <= {1'b0, pc2_ff} - {1'b0, pd_ff};
               state_ff   <= F_RES;
            end
            F_RES: begin
               res_ff.sc_zero <= sc_zero_ff;
               res_ff.cov_low <= cov_low;
               res_ff.pos     <= !cov_ff[PW] && (cov_ff != '0);
               done_ff        <= 1'b1;
               state_ff       <= F_IDLE;
            end
            default: state_ff <= F_IDLE;
         endcase
      end
   end

   assign done = done_ff;
   assign res  = res_ff;

endmodule

FILE: src/regression_concurrency_tuner.sv
// ----------------------------------------------------------------------------
// regression_concurrency_tuner
// Concurrency limit recommender: samples completion rate per tick interval
// and moves the limit by the sign of a least-squares fit of rate on load (up if unclear).
// ----------------------------------------------------------------------------
// Flow: a tick or a completion that closes no sample answers in the cycle after
//   acceptance. A closing completion passes the 25-step rate divider (skipped when no
//   tick has elapsed), the window walk over the single memory read port and the
//   shift-add product unit, then waits in S_OUT for a free output register.
// Throughput: one transaction at a time; a new one is taken in S_IDLE once the output
//   register is empty or its result is being taken (rsp_tready).
// Reset: synchronous; counters, window fill and head clear, the limit loads 1,
//   configuration registers return to their defaults. Window memory needs no clearing.
// ----------------------------------------------------------------------------
module regression_concurrency_tuner
   import rct_pkg::*;
#(
   parameter int WINDOW = 16
) (
   input  logic        clock,
   input  logic        reset,
   // input channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,    // [9:0] current_concurrency
   input  logic        req_tuser,    // [0] cmd
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,    // [9:0] recommended_limit, [41:10] velocity,
                                     // [43:42] adjust
   output logic        rsp_tuser,    // [0] sample_taken
   // configuration
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wr_data
);

   localparam int NW = $clog2(WINDOW + 1);
   localparam int IW = $clog2(WINDOW);

   localparam logic [1:0] CSR_SAMPLE_INTERVAL = 2'd0;
   localparam logic [1:0] CSR_MIN_LIMIT       = 2'd1;
   localparam logic [1:0] CSR_MAX_LIMIT       = 2'd2;
   localparam logic [1:0] CSR_INITIAL_LIMIT   = 2'd3;

   localparam logic CMD_COMPLETION = 1'b0;

   localparam logic [1:0] ADJ_NONE = 2'd0;
   localparam logic [1:0] ADJ_UP   = 2'd1;
   localparam logic [1:0] ADJ_DOWN = 2'd2;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_DIV   = 3'd1;
   localparam logic [2:0] S_WRITE = 3'd2;
   localparam logic [2:0] S_START = 3'd3;
   localparam logic [2:0] S_FIT   = 3'd4;
   localparam logic [2:0] S_APPLY = 3'd5;
   localparam logic [2:0] S_OUT   = 3'd6;

   logic [15:0]       interval_ff;
   logic [9:0]        min_ff, max_ff;
   logic [9:0]        limit_ff;
   logic [15:0]       count_ff;
   logic [31:0]       elapsed_ff;
   logic [IW-1:0]     head_ff;
   logic [NW-1:0]     fill_ff;
   logic [31:0]       last_rate_ff;
   logic [31:0]       rate_ff;
   logic [9:0]        conc_ff;
   logic [2:0]        state_ff;
   logic              up_ff;
   logic [1:0]        adj_ff;

   logic              rsp_vld_ff;
   logic [9:0]        o_limit_ff;
   logic              o_taken_ff;
   logic [31:0]       o_vel_ff;
   logic [1:0]        o_adj_ff;

   logic              out_free;
   logic              accept;
   logic [16:0]       cnt_in;
   logic              div_start;
   logic              div_done;
   logic [DVD_W-1:0]  div_q;
   logic              fit_start;
   logic              fit_done;
   fit_res_type       fit_res;

   assign out_free   = !rsp_vld_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE) && out_free;
   assign accept     = req_tvalid && req_tready;
   assign cnt_in     = {1'b0, count_ff} + 17'd1;
   assign div_start  = accept && (req_tuser == CMD_COMPLETION)
                       && (cnt_in >= {1'b0, interval_ff}) && (elapsed_ff != '0);
   assign fit_start  = (state_ff == S_START) && (fill_ff >= NW'(2));

   rct_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend ({cnt_in, 8'd0}),
      .divisor  (elapsed_ff),
      .done     (div_done),
      .quotient (div_q)
   );

   rct_fit #(.WINDOW(WINDOW)) u_fit (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (state_ff == S_WRITE),
      .wr_addr (head_ff),
      .wr_load (conc_ff),
      .wr_rate (rate_ff),
      .start   (fit_start),
      .n       (fill_ff),
      .done    (fit_done),
      .res     (fit_res)
   );

   // control sequencer, state and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         interval_ff  <= 16'd16;
         min_ff       <= 10'd1;
         max_ff       <= 10'd1023;
         limit_ff     <= 10'd1;
         count_ff     <= '0;
         elapsed_ff   <= '0;
         head_ff      <= '0;
         fill_ff      <= '0;
         last_rate_ff <= '0;
         state_ff     <= S_IDLE;
         rsp_vld_ff   <= 1'b0;
      end else begin
         if (rsp_vld_ff && rsp_tready) begin
            rsp_vld_ff <= 1'b0;
         end
         // configuration writes
         if (csr_wr_en) begin
            case (csr_index)
               CSR_SAMPLE_INTERVAL: interval_ff <= csr_wr_data;
               CSR_MIN_LIMIT:       min_ff      <= csr_wr_data[9:0];
               CSR_MAX_LIMIT:       max_ff      <= csr_wr_data[9:0];
               CSR_INITIAL_LIMIT:   limit_ff    <= csr_wr_data[9:0];
               default: ;
            endcase
         end
         case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  conc_ff <= req_tdata[9:0];
                  if (req_tuser != CMD_COMPLETION || cnt_in < {1'b0, interval_ff}) begin
                     // tick or plain completion: answer at once
                     if (req_tuser != CMD_COMPLETION) begin
                        if (elapsed_ff != 32'hFFFF_FFFF) begin
                           elapsed_ff <= elapsed_ff + 32'd1;
                        end
                     end else begin
                        count_ff <= cnt_in[15:0];
                     end
                     rsp_vld_ff <= 1'b1;
                     o_limit_ff <= limit_ff;
                     o_taken_ff <= 1'b0;
                     o_vel_ff   <= last_rate_ff;
                     o_adj_ff   <= ADJ_NONE;
                  end else if (elapsed_ff == '0) begin
                     rate_ff  <= 32'hFFFF_FFFF;
                     state_ff <= S_WRITE;
                  end else begin
                     state_ff <= S_DIV;
                  end
               end
            end
            S_DIV: begin
               if (div_done) begin
                  rate_ff  <= 32'(div_q);
                  state_ff <= S_WRITE;
               end
            end
            S_WRITE: begin
               // new sample goes into the ring
               head_ff      <= (head_ff == IW'(WINDOW - 1)) ? '0 : head_ff + 1'b1;
               if (fill_ff < NW'(WINDOW)) begin
                  fill_ff <= fill_ff + 1'b1;
               end
               last_rate_ff <= rate_ff;
               elapsed_ff   <= '0;
               count_ff     <= '0;
               state_ff     <= S_START;
            end
            S_START: begin
               if (fill_ff < NW'(2)) begin
                  up_ff    <= 1'b1;
                  state_ff <= S_APPLY;
               end else begin
                  state_ff <= S_FIT;
               end
            end
            S_FIT: begin
               if (fit_done) begin
                  up_ff    <= fit_res.sc_zero || fit_res.cov_low || fit_res.pos;
                  state_ff <= S_APPLY;
               end
            end
            S_APPLY: begin
               // bounded step of the limit
               if (up_ff && limit_ff < max_ff) begin
                  limit_ff <= limit_ff + 10'd1;
                  adj_ff   <= ADJ_UP;
               end else if (!up_ff && limit_ff > min_ff) begin
                  limit_ff <= limit_ff - 10'd1;
                  adj_ff   <= ADJ_DOWN;
               end else begin
                  adj_ff <= ADJ_NONE;
               end
               state_ff <= S_OUT;
            end
            S_OUT: begin
               if (out_free) begin
                  rsp_vld_ff <= 1'b1;
                  o_limit_ff <= limit_ff;
                  o_taken_ff <= 1'b1;
                  o_vel_ff   <= last_rate_ff;
                  o_adj_ff   <= adj_ff;
                  state_ff   <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = {4'd0, o_adj_ff, o_vel_ff, o_limit_ff};
   assign rsp_tuser  = o_taken_ff;

   // ---------------------------------------------------------------------
   // assertions
   // ---------------------------------------------------------------------
   a_accept_idle: assert property (@(posedge clock) disable iff (reset)
      accept |-> (state_ff == S_IDLE))
      else $error("transaction accepted while a sample is in progress");

   a_limit_step: assert property (@(posedge clock) disable iff (reset)
      (!$past(csr_wr_en) && !$past(reset) && limit_ff != $past(limit_ff)) |->
      (limit_ff == $past(limit_ff) + 10'd1 || limit_ff + 10'd1 == $past(limit_ff)))
      else $error("limit moved by more than one step");

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= NW'(WINDOW))
      else $error("window fill beyond depth");

   a_taken_adj: assert property (@(posedge clock) disable iff (reset)
      (rsp_vld_ff && !o_taken_ff) |-> (o_adj_ff == ADJ_NONE))
      else $error("adjust reported without a sample");

endmodule
